>>> src/ptc_pkg.sv
// package for the temperature compensated adc block
// holds field widths, register indexes, side codes, the temperature point reset value and divider widths
// no dependencies
package ptc_pkg;

  localparam int AdcBitsDefault = 24;
  localparam int CfgIndexBits   = 3;
  localparam int CfgDataBits    = 32;

  localparam logic [CfgIndexBits-1:0] RegCompEnable   = 3'd0;
  localparam logic [CfgIndexBits-1:0] RegTempPoints   = 3'd1;
  localparam logic [CfgIndexBits-1:0] RegCalZero      = 3'd2;
  localparam logic [CfgIndexBits-1:0] RegCalSpan      = 3'd3;
  localparam logic [CfgIndexBits-1:0] RegHighDrift    = 3'd4;
  localparam logic [CfgIndexBits-1:0] RegLowDrift     = 3'd5;
  localparam logic [CfgIndexBits-1:0] RegRecalOffsets = 3'd6;

  localparam logic [1:0] SideMid  = 2'd0;
  localparam logic [1:0] SideHigh = 2'd1;
  localparam logic [1:0] SideLow  = 2'd2;

  localparam logic [23:0] TempPointsReset = 24'h9C9C9C;

  // radix-2 restoring divider widths (magnitudes)
  localparam int DrNumBits = 25; // |drift*num| < 2^24
  localparam int DrDenBits = 9;
  localparam int RsNumBits = 60; // |(raw-adj_zero)*(cs-cz)|
  localparam int RsDenBits = 34;

endpackage

>>> src/ptc_divider.sv
// pipelined signed divider, truncating toward zero, one quotient bit per stage
// depends on nothing; used by the top level of the temperature compensated adc
module ptc_divider #(
  parameter int NumBits = 25,
  parameter int DenBits = 9,
  parameter int TagBits = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [NumBits:0]   num,
  input  logic [DenBits:0]   den,
  input  logic [TagBits-1:0] tag_in,
  output logic               out_valid,
  output logic [NumBits:0]   quot,
  output logic [TagBits-1:0] tag_out
);
  // num and den are signed two's complement, one bit wider than the magnitudes

  logic [NumBits-1:0] q   [NumBits+1];
  logic [NumBits-1:0] r   [NumBits+1];
  logic [DenBits-1:0] d   [NumBits+1];
  logic               neg [NumBits+1];
  logic               vld [NumBits+1];
  logic [TagBits-1:0] tg  [NumBits+1];

  logic [NumBits:0] num_mag;
  logic [DenBits:0] den_mag;

  assign num_mag = num[NumBits] ? (~num + 1'b1) : num;
  assign den_mag = den[DenBits] ? (~den + 1'b1) : den;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q[0]   <= num_mag[NumBits-1:0];
      r[0]   <= '0;
      d[0]   <= den_mag[DenBits-1:0];
      neg[0] <= num[NumBits] ^ den[DenBits];
      tg[0]  <= tag_in;
    end
  end

  for (genvar s = 0; s < NumBits; s++) begin : g_stage
    logic [DenBits:0] trial;
    logic [DenBits:0] rem_sh;
    assign rem_sh = {r[s][DenBits-1:0], q[s][NumBits-1]};
    assign trial  = rem_sh - {1'b0, d[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!trial[DenBits]) begin
          r[s+1] <= NumBits'(trial[DenBits-1:0]);
          q[s+1] <= {q[s][NumBits-2:0], 1'b1};
        end else begin
          r[s+1] <= NumBits'(rem_sh[DenBits-1:0]);
          q[s+1] <= {q[s][NumBits-2:0], 1'b0};
        end
        d[s+1]   <= d[s];
        neg[s+1] <= neg[s];
        tg[s+1]  <= tg[s];
      end
    end
  end

  assign out_valid = vld[NumBits];
  assign quot      = neg[NumBits] ? (~{1'b0, q[NumBits]} + 1'b1) : {1'b0, q[NumBits]};
  assign tag_out   = tg[NumBits];

endmodule

>>> src/piecewise_temp_comp_adc_top.sv
// temperature compensated adc: clamp, drift interpolation and rescale pipeline
// depends on ptc_pkg and ptc_divider
// stages in order: a, b, drift dividers, c, e, rescale divider, output register
// throughput: one request per cycle unless the output stalls; each pipelined divider stage holds one sample
// a stall on the output freezes the whole pipeline, so nothing is lost or repeated
// reset (rst, synchronous): config registers go to their reset values, all stages empty
module piecewise_temp_comp_adc_top #(
  parameter int ADC_BITS = ptc_pkg::AdcBitsDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ptc_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [ptc_pkg::CfgDataBits-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [ADC_BITS-1:0]       raw_count,
  input  logic signed [7:0]                temperature,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [31:0]               compensated_count,
  output logic [1:0]                       side_used,
  output logic                             div_fault
);
  import ptc_pkg::*;

  localparam int RawW = ADC_BITS;

  logic        comp_enable;
  logic [23:0] temp_points;
  logic [23:0] cal_zero, cal_span;
  logic [31:0] high_side_drift, low_side_drift, recal_offsets;

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_enable <= 1'b0;
      temp_points <= TempPointsReset;
      cal_zero <= '0; cal_span <= '0;
      high_side_drift <= '0; low_side_drift <= '0; recal_offsets <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        RegCompEnable:   comp_enable     <= cfg_data[0];
        RegTempPoints:   temp_points     <= cfg_data[23:0];
        RegCalZero:      cal_zero        <= cfg_data[23:0];
        RegCalSpan:      cal_span        <= cfg_data[23:0];
        RegHighDrift:    high_side_drift <= cfg_data;
        RegLowDrift:     low_side_drift  <= cfg_data;
        RegRecalOffsets: recal_offsets   <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves together; output register is the last stage
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage a: clamp and side select
  logic signed [7:0] lo, mid, hi, tc;
  assign lo  = temp_points[7:0];
  assign mid = temp_points[15:8];
  assign hi  = temp_points[23:16];
  always_comb begin
    if (temperature > hi) tc = hi;
    else if (temperature < lo) tc = lo;
    else tc = temperature;
  end

  logic                    a_vld, a_en;
  logic signed [RawW-1:0]  a_raw;
  logic [1:0]              a_side;
  logic signed [8:0]       a_num, a_den;
  logic signed [15:0]      a_dz, a_ds;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (adv) a_vld <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_en  <= comp_enable;
      a_raw <= raw_count;
      a_num <= 9'(mid) - 9'(tc);
      if (tc > mid) begin
        a_side <= SideHigh;
        a_den  <= 9'(mid) - 9'(hi);
        a_dz   <= high_side_drift[15:0];
        a_ds   <= high_side_drift[31:16];
      end else if (tc < mid) begin
        a_side <= SideLow;
        a_den  <= 9'(mid) - 9'(lo);
        a_dz   <= low_side_drift[15:0];
        a_ds   <= low_side_drift[31:16];
      end else begin
        a_side <= SideMid;
        a_den  <= '0;
        a_dz   <= '0;
        a_ds   <= '0;
      end
    end
  end

  // stage b: drift products
  logic                   b_vld, b_en, b_zden;
  logic signed [RawW-1:0] b_raw;
  logic [1:0]             b_side;
  logic signed [DrDenBits:0] b_den;
  logic signed [DrNumBits:0] b_pz, b_ps;

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (adv) b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_en   <= a_en;
      b_raw  <= a_raw;
      b_side <= a_side;
      b_den  <= (a_den == 9'sd0) ? (DrDenBits+1)'(1) : (DrDenBits+1)'(a_den);
      b_zden <= (a_den == 9'sd0);
      b_pz   <= (DrNumBits+1)'(a_dz * a_num);
      b_ps   <= (DrNumBits+1)'(a_ds * a_num);
    end
  end

  // drift dividers, tag carries the sideband
  localparam int TagA = RawW + 4;
  logic [TagA-1:0]           dz_tag, ds_tag_unused_in, dz_tag_out, ds_tag_out;
  logic                      dz_vld, ds_vld;
  logic signed [DrNumBits:0] dz_q, ds_q;

  assign dz_tag = {b_en, b_zden, b_side, b_raw};
  assign ds_tag_unused_in = dz_tag;

  ptc_divider #(.NumBits(DrNumBits), .DenBits(DrDenBits), .TagBits(TagA)) u_div_zero (
    .clk, .rst, .adv, .in_valid(b_vld), .num(b_pz), .den(b_den), .tag_in(dz_tag),
    .out_valid(dz_vld), .quot(dz_q), .tag_out(dz_tag_out)
  );

  ptc_divider #(.NumBits(DrNumBits), .DenBits(DrDenBits), .TagBits(TagA)) u_div_span (
    .clk, .rst, .adv, .in_valid(b_vld), .num(b_ps), .den(b_den),
    .tag_in(ds_tag_unused_in), .out_valid(ds_vld), .quot(ds_q), .tag_out(ds_tag_out)
  );

  // stage c: adjusted zero and span
  logic                   c_vld, c_en;
  logic signed [RawW-1:0] c_raw;
  logic [1:0]             c_side;
  logic signed [33:0]     c_diffnum;
  logic signed [33:0]     c_den;
  logic signed [25:0]     c_cscz;

  logic                   d_en, d_zden;
  logic [1:0]             d_side;
  logic signed [RawW-1:0] d_raw;
  logic signed [27:0]     adj_zero, adj_span;
  assign {d_en, d_zden, d_side, d_raw} = dz_tag_out;
  assign adj_zero = 28'($signed(cal_zero)) + 28'($signed(recal_offsets[15:0]))
                  - (d_zden ? 28'sd0 : 28'(dz_q));
  assign adj_span = 28'($signed(cal_span)) + 28'($signed(recal_offsets[31:16]))
                  - (d_zden ? 28'sd0 : 28'(ds_q));

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else if (adv) c_vld <= dz_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_en      <= d_en;
      c_raw     <= d_raw;
      c_side    <= d_side;
      c_diffnum <= 34'(d_raw) - 34'(adj_zero);
      c_den     <= 34'(adj_span) - 34'(adj_zero);
      c_cscz    <= 26'($signed(cal_span)) - 26'($signed(cal_zero));
    end
  end

  // stage e: rescale product
  logic                    e_vld, e_en, e_fault;
  logic signed [RawW-1:0]  e_raw;
  logic [1:0]              e_side;
  logic signed [RsNumBits:0] e_prod;
  logic signed [RsDenBits:0] e_den;

  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else if (adv) e_vld <= c_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_en    <= c_en;
      e_raw   <= c_raw;
      e_side  <= c_side;
      e_fault <= (c_den == 34'sd0);
      e_den   <= (c_den == 34'sd0) ? 35'sd1 : 35'(c_den);
      e_prod  <= (RsNumBits+1)'(c_diffnum * c_cscz);
    end
  end

  localparam int TagB = RawW + 4;
  logic [TagB-1:0]            r_tag_in, r_tag_out;
  logic                       r_vld;
  logic signed [RsNumBits:0]  r_q;
  assign r_tag_in = {e_en, e_fault, e_side, e_raw};

  ptc_divider #(.NumBits(RsNumBits), .DenBits(RsDenBits), .TagBits(TagB)) u_div_rescale (
    .clk, .rst, .adv, .in_valid(e_vld), .num(e_prod), .den(e_den), .tag_in(r_tag_in),
    .out_valid(r_vld), .quot(r_q), .tag_out(r_tag_out)
  );

  logic                     f_en, f_fault;
  logic [1:0]               f_side;
  logic signed [RawW-1:0]   f_raw;
  logic signed [RsNumBits+1:0] f_res;
  assign {f_en, f_fault, f_side, f_raw} = r_tag_out;
  assign f_res = (RsNumBits+2)'(r_q) + (RsNumBits+2)'($signed(cal_zero));

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= r_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!f_en || f_fault) begin
        compensated_count <= 32'(f_raw);
      end else if (f_res > (RsNumBits+2)'(64'sd2147483647)) begin
        compensated_count <= 32'sh7FFFFFFF;
      end else if (f_res < -(RsNumBits+2)'(64'sd2147483648)) begin
        compensated_count <= 32'sh80000000;
      end else begin
        compensated_count <= 32'(f_res);
      end
      side_used <= f_en ? f_side : SideMid;
      div_fault <= f_en && f_fault;
    end
  end

  a_dz_ds_lockstep: assert property (@(posedge clk) disable iff (rst) dz_vld == ds_vld)
    else $error("drift dividers out of step");
  a_tag_match: assert property (@(posedge clk) disable iff (rst)
      dz_vld |-> dz_tag_out == ds_tag_out)
    else $error("drift divider sideband mismatch");
  a_fault_side: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> side_used != 2'd3)
    else $error("bad side code");
  a_hold: assert property (@(posedge clk) disable iff (rst)
      !adv |=> $stable(compensated_count))
    else $error("result changed under stall");

endmodule

>>> tb/sv/piecewise_temp_comp_adc_top_test.sv
// testbench for piecewise_temp_comp_adc_top: random and directed samples checked against
// a bit-exact compensation predictor held in a small scoreboard class
// depends on ptc_pkg and the block's rtl
`timescale 1ns / 100ps

class comp_scoreboard;
  bit [0:0]  en;
  bit [23:0] points;
  bit [23:0] czero;
  bit [23:0] cspan;
  bit [31:0] hdrift;
  bit [31:0] ldrift;
  bit [31:0] recal;
  bit [34:0] pending[$];
  int        mismatches;

  function void reset_regs();
    en = 0; points = ptc_pkg::TempPointsReset; czero = 0; cspan = 0;
    hdrift = 0; ldrift = 0; recal = 0;
  endfunction

  function void write_reg(bit [2:0] idx, bit [31:0] val);
    case (idx)
      ptc_pkg::RegCompEnable:   en = val[0];
      ptc_pkg::RegTempPoints:   points = val[23:0];
      ptc_pkg::RegCalZero:      czero = val[23:0];
      ptc_pkg::RegCalSpan:      cspan = val[23:0];
      ptc_pkg::RegHighDrift:    hdrift = val;
      ptc_pkg::RegLowDrift:     ldrift = val;
      ptc_pkg::RegRecalOffsets: recal = val;
      default: ;
    endcase
  endfunction

  function longint drift_term(longint drift, longint num, longint den);
    if (den == 0) return 0;
    return (drift * num) / den;
  endfunction

  // packs count, side and fault for one sample
  function void note_sample(bit [23:0] raw_bits, bit [7:0] temp_bits);
    longint raw, t, lo, mid, hi, cz, cs, az, aspan, res;
    bit [1:0] side;
    bit fault;
    raw = longint'($signed(raw_bits));
    t = longint'($signed(temp_bits));
    side = ptc_pkg::SideMid;
    fault = 0;
    if (!en) begin
      pending.push_back({1'b0, ptc_pkg::SideMid, raw[31:0]});
      return;
    end
    lo = longint'($signed(points[7:0]));
    mid = longint'($signed(points[15:8]));
    hi = longint'($signed(points[23:16]));
    cz = longint'($signed(czero));
    cs = longint'($signed(cspan));
    if (t > hi) t = hi;
    else if (t < lo) t = lo;
    az = cz + longint'($signed(recal[15:0]));
    aspan = cs + longint'($signed(recal[31:16]));
    if (t > mid) begin
      side = ptc_pkg::SideHigh;
      az -= drift_term(longint'($signed(hdrift[15:0])), mid - t, mid - hi);
      aspan -= drift_term(longint'($signed(hdrift[31:16])), mid - t, mid - hi);
    end else if (t < mid) begin
      side = ptc_pkg::SideLow;
      az -= drift_term(longint'($signed(ldrift[15:0])), mid - t, mid - lo);
      aspan -= drift_term(longint'($signed(ldrift[31:16])), mid - t, mid - lo);
    end
    if (aspan == az) begin
      fault = 1;
      res = raw;
    end else begin
      res = ((raw - az) * (cs - cz)) / (aspan - az) + cz;
    end
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    else if (res < -64'sd2147483648) res = -64'sd2147483648;
    pending.push_back({fault, side, res[31:0]});
  endfunction

  function void check_result(bit [31:0] cnt, bit [1:0] side, bit fault);
    bit [34:0] exp_r;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h %0d %0d", cnt, side, fault);
      return;
    end
    exp_r = pending.pop_front();
    if (exp_r != {fault, side, cnt}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected count %h side %0d fault %0d, got %h %0d %0d",
                 exp_r[31:0], exp_r[33:32], exp_r[34], cnt, side, fault);
    end
  endfunction
endclass

module piecewise_temp_comp_adc_top_test;
  import ptc_pkg::*;

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [CfgIndexBits-1:0] cfg_index = RegCompEnable;
  logic [CfgDataBits-1:0] cfg_data = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [23:0] raw_count = 0;
  logic signed [7:0] temperature = 0;
  logic signed [31:0] compensated_count;
  logic [1:0] side_used;
  logic div_fault;

  comp_scoreboard sb;
  int cycles = 0;
  int hold_off = 0;
  bit stim_done = 0;
  localparam int Latency = 100;
  localparam int CycleLimit = 400000;

  piecewise_temp_comp_adc_top DUT (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_result(compensated_count, side_used, div_fault);

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int mode;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_stall <= 1;
        hold_off--;
      end else begin
        mode = (cycles / 500) % 3;
        if (mode == 0) out_stall <= 0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  task automatic write_cfg(bit [2:0] idx, bit [31:0] val);
    @(negedge clk);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_write <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (Latency) @(negedge clk);
  endtask

  // offers one request at this falling edge and holds it until accepted
  task automatic send(bit [23:0] r, bit [7:0] t);
    in_valid <= 1; raw_count <= r; temperature <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(r, t);
    @(negedge clk);
  endtask

  task automatic send_burst(int n, bit well_formed);
    int burst;
    int gap;
    bit [23:0] r;
    bit [7:0] t;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid <= 0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 30);
      end
      r = $urandom;
      if (well_formed && $urandom_range(0, 3) != 0) r = $urandom_range(0, 20000) - 10000;
      t = $urandom;
      if (well_formed && $urandom_range(0, 1)) t = $urandom_range(0, 100) - 50;
      send(r, t);
      burst--;
    end
    in_valid <= 0;
  endtask

  task automatic random_config(bit wide);
    write_cfg(RegCompEnable, $urandom_range(0, 4) != 0);
    if (wide) write_cfg(RegTempPoints, $urandom);
    else write_cfg(RegTempPoints, {8'($urandom_range(20, 90)), 8'($urandom_range(0, 10) - 5),
                                   8'(-$urandom_range(20, 90))});
    write_cfg(RegCalZero, wide ? $urandom : $urandom_range(0, 2000) - 1000);
    write_cfg(RegCalSpan, wide ? $urandom : $urandom_range(100000, 4000000));
    write_cfg(RegHighDrift, $urandom);
    write_cfg(RegLowDrift, $urandom);
    write_cfg(RegRecalOffsets, wide ? $urandom : {16'($urandom_range(0, 200) - 100),
                                                  16'($urandom_range(0, 200) - 100)});
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // disabled pass-through at field extremes
    send(24'h800000, 8'h80); send(24'h7FFFFF, 8'h7F); send(24'h000000, 8'h00);
    in_valid <= 0;
    drain();
    write_cfg(RegCompEnable, 1);
    write_cfg(RegTempPoints, {8'd60, 8'd20, -8'sd40});
    write_cfg(RegCalZero, 24'd100);
    write_cfg(RegCalSpan, 24'd500000);
    write_cfg(RegHighDrift, {16'h8000, 16'h7FFF});
    write_cfg(RegLowDrift, {16'h7FFF, 16'h8000});
    write_cfg(RegRecalOffsets, {16'sd5, -16'sd3});
    // mid, high side, low side, clamps and extreme raw counts
    send(24'd1000, 8'd20); send(24'd1000, 8'd40); send(24'd1000, 8'd127);
    send(24'd1000, 8'd0); send(24'd1000, 8'h80); send(24'h7FFFFF, 8'd60);
    send(24'h800000, -8'sd40);
    in_valid <= 0;
    drain();
    // division fault: span equals zero; then a span just one above zero
    write_cfg(RegCalSpan, 24'd100);
    write_cfg(RegRecalOffsets, 32'h0);
    send(24'd1234, 8'd20); send(24'h800000, 8'd20);
    in_valid <= 0;
    drain();
    write_cfg(RegCalZero, 24'hFFFFFF);
    write_cfg(RegCalSpan, 24'h7FFFFF);
    write_cfg(RegCalZero, 24'h800000);
    write_cfg(RegCalZero, 24'd0);
    write_cfg(RegCalSpan, 24'd1);
    write_cfg(RegRecalOffsets, {16'sd0, 16'sd0});
    write_cfg(RegHighDrift, 0); write_cfg(RegLowDrift, 0);
    write_cfg(RegCalSpan, 24'h7FFFFF);
    write_cfg(RegCalZero, 24'h7FFFFE);
    send(24'h800000, 8'd20); send(24'h7FFFFF, 8'd20);
    in_valid <= 0;
    drain();
    // points out of order, zero side width
    write_cfg(RegTempPoints, {-8'sd10, 8'd30, 8'd30});
    write_cfg(RegHighDrift, $urandom); write_cfg(RegLowDrift, $urandom);
    send(24'd5000, 8'd0); send(24'd5000, 8'd50); send(24'd5000, -8'sd20);
    in_valid <= 0;
    drain();
    // long receiver hold-off while the sender keeps offering
    hold_off = 400;
    random_config(0);
    send_burst(200, 1);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      random_config(ph == 3 || ph == 7);
      send_burst(100, ph != 7);
      drain();
    end
    stim_done = 1;
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/ptc_pkg.sv
src/ptc_divider.sv
src/piecewise_temp_comp_adc_top.sv
tb/sv/piecewise_temp_comp_adc_top_test.sv
